// File: rtl/core/delta_list_timer_queue_assert.svh
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH

// condition must never hold
`define DLTQ_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DLTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DLTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dltq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;

    localparam int TIME_W          = 32;
    localparam int DEF_NUM_TIMERS  = 16;
    localparam int ID_W            = 4;
    localparam int SPACING_W       = 16;
    localparam logic [SPACING_W-1:0] MIN_SPACING_RST = 16'd2;

    localparam logic [1:0] FUNC_ARM    = 2'd0;
    localparam logic [1:0] FUNC_DISARM = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ARMED     = 2'd1;
    localparam logic [1:0] ST_NOT_ARMED = 2'd2;
    localparam logic [1:0] ST_ZERO      = 2'd3;

    typedef logic [TIME_W-1:0] time_t;

endpackage
`default_nettype wire

// File: rtl/core/delta_list_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// One-shot timer pool kept as a delta-ordered linked list in three synchronous
// memories (next link, prev link, gap) that share one read address. One request
// is handled at a time. An arm into a non-empty list walks the list entries (up
// to NUM_TIMERS) to find its place; a disarm of an armed timer unlinks it; a tick
// removes each expired timer from the front of the list. Results then leave one
// per cycle while out_ready is high; a tick gives one result per expired timer,
// all showing the final alarm state. The list walk reads one node per cycle. The
// memories need no clearing after reset: only linked entries are ever read.
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [SPACING_W-1:0] cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           func,
    input  wire logic [ID_W-1:0]      timer_id,
    input  wire logic [TIME_W-1:0]    delay,
    input  wire logic [TIME_W-1:0]    now,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ID_W-1:0]           expired_id,
    output logic                      expired,
    output logic [TIME_W-1:0]         alarm_time,
    output logic                      alarm_on,
    output logic [1:0]                status,
    output logic                      last
);

    localparam int NW = $clog2(NUM_TIMERS + 1);
    localparam int IW = $clog2(NUM_TIMERS);
    localparam logic [NW-1:0] HEAD = NW'(NUM_TIMERS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] A_FIRST = 4'd2;
    localparam logic [3:0] A_WALK  = 4'd3;
    localparam logic [3:0] A_INS2  = 4'd4;
    localparam logic [3:0] D_RD    = 4'd5;
    localparam logic [3:0] D_UPD   = 4'd6;
    localparam logic [3:0] D_ALM   = 4'd7;
    localparam logic [3:0] T_CHK   = 4'd8;
    localparam logic [3:0] T_ALM   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [SPACING_W-1:0]  spacing_reg, spacing_next;
    logic [1:0]            func_reg, func_next;
    logic [NW-1:0]         id_reg, id_next;
    logic                  id_ok_reg, id_ok_next;
    time_t                 delay_reg, delay_next;
    time_t                 now_reg, now_next;
    logic [1:0]            status_reg, status_next;
    logic [NW-1:0]         p_reg, p_next;
    logic [NW-1:0]         pp_reg, pp_next;
    time_t                 f_reg, f_next;
    time_t                 nd_reg, nd_next;
    time_t                 g_reg, g_next;
    logic                  wrap_reg, wrap_next;
    logic                  first_reg, first_next;
    time_t                 base_reg, base_next;
    time_t                 alarm_reg, alarm_next;
    logic                  alen_reg, alen_next;
    logic [NW-1:0]         hnext_reg, hnext_next;
    logic [NW-1:0]         hprev_reg, hprev_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic [NW-1:0]         k_reg, k_next;

    logic [NW-1:0] nl_mem [NUM_TIMERS];
    logic [NW-1:0] pl_mem [NUM_TIMERS];
    time_t         gap_mem [NUM_TIMERS];
    logic [NW-1:0] fifo_mem [NUM_TIMERS];

    logic [NW-1:0] nl_q, pl_q;
    time_t         gap_q;
    logic [NW-1:0] exp_q;
    logic [IW-1:0] rd_a;
    logic          nl_we, pl_we, gap_we, fifo_we;
    logic [IW-1:0] nl_wa, pl_wa, gap_wa;
    logic [NW-1:0] nl_wd, pl_wd;
    time_t         gap_wd;

    time_t         minsp;
    time_t         dl;
    time_t         d_w;
    logic [TIME_W:0] sum_w;
    logic [31:0]   id_wide;
    logic [31:0]   exp_wide;
    logic [NW-1:0] n_out;
    logic          is_exp;

    assign minsp   = {{(TIME_W-SPACING_W){1'b0}}, spacing_reg};
    assign id_wide = {{(32-ID_W){1'b0}}, timer_id};

    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            nl_mem[nl_wa] <= nl_wd;
        end
        if (pl_we)
        begin
            pl_mem[pl_wa] <= pl_wd;
        end
        if (gap_we)
        begin
            gap_mem[gap_wa] <= gap_wd;
        end
        nl_q  <= nl_mem[rd_a];
        pl_q  <= pl_mem[rd_a];
        gap_q <= gap_mem[rd_a];
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[cnt_reg[IW-1:0]] <= p_reg;
        end
        if (fifo_we && (cnt_reg == k_next))
        begin
            exp_q <= p_reg;
        end
        else
        begin
            exp_q <= fifo_mem[k_next[IW-1:0]];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        spacing_next = cfg_we ? cfg_wdata : spacing_reg;
        func_next   = func_reg;
        id_next     = id_reg;
        id_ok_next  = id_ok_reg;
        delay_next  = delay_reg;
        now_next    = now_reg;
        status_next = status_reg;
        p_next      = p_reg;
        pp_next     = pp_reg;
        f_next      = f_reg;
        nd_next     = nd_reg;
        g_next      = g_reg;
        wrap_next   = wrap_reg;
        first_next  = first_reg;
        base_next   = base_reg;
        alarm_next  = alarm_reg;
        alen_next   = alen_reg;
        hnext_next  = hnext_reg;
        hprev_next  = hprev_reg;
        armed_next  = armed_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        rd_a        = p_reg[IW-1:0];
        nl_we = 1'b0; nl_wa = id_reg[IW-1:0]; nl_wd = HEAD;
        pl_we = 1'b0; pl_wa = id_reg[IW-1:0]; pl_wd = HEAD;
        gap_we = 1'b0; gap_wa = id_reg[IW-1:0]; gap_wd = f_reg;
        fifo_we = 1'b0;
        dl    = (delay_reg < minsp) ? minsp : delay_reg;
        sum_w = '0;
        d_w   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func;
                    id_next     = id_wide[NW-1:0];
                    id_ok_next  = (id_wide < 32'(NUM_TIMERS));
                    delay_next  = delay;
                    now_next    = now;
                    status_next = ST_OK;
                    cnt_next    = '0;
                    k_next      = '0;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_OUT;
                unique case (func_reg)
                    FUNC_TICK:
                    begin
                        nd_next = now_reg - base_reg;
                        if (hnext_reg != HEAD)
                        begin
                            p_next     = hnext_reg;
                            rd_a       = hnext_reg[IW-1:0];
                            state_next = T_CHK;
                        end
                    end
                    FUNC_ARM:
                    begin
                        if (!id_ok_reg)
                        begin
                            status_next = ST_NOT_ARMED;
                        end
                        else if (delay_reg == '0)
                        begin
                            status_next = ST_ZERO;
                        end
                        else if (armed_reg[id_reg[IW-1:0]])
                        begin
                            status_next = ST_ARMED;
                        end
                        else
                        begin
                            armed_next[id_reg[IW-1:0]] = 1'b1;
                            if (hnext_reg == HEAD)
                            begin
                                base_next  = now_reg;
                                hnext_next = id_reg;
                                hprev_next = id_reg;
                                nl_we  = 1'b1;
                                pl_we  = 1'b1;
                                gap_we = 1'b1;
                                gap_wd = dl;
                                alarm_next = now_reg + dl;
                                alen_next  = 1'b1;
                            end
                            else
                            begin
                                p_next     = hnext_reg;
                                nd_next    = now_reg - base_reg;
                                sum_w      = {1'b0, now_reg - base_reg} + {1'b0, dl};
                                wrap_next  = sum_w[TIME_W];
                                f_next     = sum_w[TIME_W-1:0];
                                rd_a       = hnext_reg[IW-1:0];
                                state_next = A_FIRST;
                            end
                        end
                    end
                    FUNC_DISARM:
                    begin
                        if (!id_ok_reg || !armed_reg[id_reg[IW-1:0]])
                        begin
                            status_next = ST_NOT_ARMED;
                        end
                        else
                        begin
                            armed_next[id_reg[IW-1:0]] = 1'b0;
                            first_next = (hnext_reg == id_reg);
                            rd_a       = id_reg[IW-1:0];
                            state_next = D_RD;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            A_FIRST:
            begin
                state_next = A_WALK;
                if (wrap_reg)
                begin
                    f_next = f_reg - gap_q;
                    p_next = nl_q;
                    rd_a   = nl_q[IW-1:0];
                end
                else if (f_reg < gap_q)
                begin
                    alarm_next = base_reg + f_reg;
                end
            end
            A_WALK:
            begin
                pp_next = (p_reg == HEAD) ? hprev_reg : pl_q;
                if (p_reg != HEAD && gap_q < f_reg)
                begin
                    f_next = f_reg - gap_q;
                    p_next = nl_q;
                    rd_a   = nl_q[IW-1:0];
                end
                else
                begin
                    nl_we  = 1'b1;
                    nl_wd  = p_reg;
                    pl_we  = 1'b1;
                    pl_wd  = (p_reg == HEAD) ? hprev_reg : pl_q;
                    gap_we = 1'b1;
                    gap_wd = f_reg;
                    g_next = gap_q;
                    state_next = A_INS2;
                end
            end
            A_INS2:
            begin
                if (pp_reg == HEAD)
                begin
                    hnext_next = id_reg;
                end
                else
                begin
                    nl_we = 1'b1;
                    nl_wa = pp_reg[IW-1:0];
                    nl_wd = id_reg;
                end
                if (p_reg == HEAD)
                begin
                    hprev_next = id_reg;
                end
                else
                begin
                    pl_we  = 1'b1;
                    pl_wa  = p_reg[IW-1:0];
                    pl_wd  = id_reg;
                    gap_we = 1'b1;
                    gap_wa = p_reg[IW-1:0];
                    gap_wd = g_reg - f_reg;
                end
                state_next = S_OUT;
            end
            D_RD:
            begin
                g_next = gap_q;
                if (pl_q == HEAD)
                begin
                    hnext_next = nl_q;
                end
                else
                begin
                    nl_we = 1'b1;
                    nl_wa = pl_q[IW-1:0];
                    nl_wd = nl_q;
                end
                if (nl_q == HEAD)
                begin
                    hprev_next = pl_q;
                end
                else
                begin
                    pl_we = 1'b1;
                    pl_wa = nl_q[IW-1:0];
                    pl_wd = pl_q;
                end
                p_next     = nl_q;
                rd_a       = nl_q[IW-1:0];
                state_next = D_UPD;
            end
            D_UPD:
            begin
                state_next = S_OUT;
                if (p_reg == HEAD)
                begin
                    if (first_reg)
                    begin
                        alen_next = 1'b0;
                    end
                end
                else
                begin
                    gap_we = 1'b1;
                    gap_wa = p_reg[IW-1:0];
                    gap_wd = gap_q + g_reg;
                    if (first_reg)
                    begin
                        f_next     = gap_q + g_reg;
                        nd_next    = now_reg - base_reg;
                        state_next = D_ALM;
                    end
                end
            end
            D_ALM:
            begin
                d_w = f_reg - nd_reg;
                if (nd_reg < f_reg)
                begin
                    alarm_next = base_reg + nd_reg + ((d_w < minsp) ? minsp : d_w);
                end
                state_next = S_OUT;
            end
            T_CHK:
            begin
                if (gap_q <= nd_reg)
                begin
                    base_next  = base_reg + gap_q;
                    nd_next    = nd_reg - gap_q;
                    hnext_next = nl_q;
                    if (nl_q == HEAD)
                    begin
                        hprev_next = HEAD;
                        alen_next  = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pl_we = 1'b1;
                        pl_wa = nl_q[IW-1:0];
                        pl_wd = HEAD;
                    end
                    armed_next[p_reg[IW-1:0]] = 1'b0;
                    fifo_we  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    p_next   = nl_q;
                    rd_a     = nl_q[IW-1:0];
                end
                else
                begin
                    base_next  = now_reg;
                    gap_we     = 1'b1;
                    gap_wa     = p_reg[IW-1:0];
                    gap_wd     = gap_q - nd_reg;
                    f_next     = gap_q - nd_reg;
                    state_next = T_ALM;
                end
            end
            T_ALM:
            begin
                alarm_next = now_reg + ((f_reg < minsp) ? minsp : f_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            spacing_reg <= MIN_SPACING_RST;
            base_reg    <= '0;
            alarm_reg   <= '0;
            alen_reg    <= 1'b0;
            hnext_reg   <= HEAD;
            hprev_reg   <= HEAD;
            armed_reg   <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            spacing_reg <= spacing_next;
            base_reg    <= base_next;
            alarm_reg   <= alarm_next;
            alen_reg    <= alen_next;
            hnext_reg   <= hnext_next;
            hprev_reg   <= hprev_next;
            armed_reg   <= armed_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        id_reg     <= id_next;
        id_ok_reg  <= id_ok_next;
        delay_reg  <= delay_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        p_reg      <= p_next;
        pp_reg     <= pp_next;
        f_reg      <= f_next;
        nd_reg     <= nd_next;
        g_reg      <= g_next;
        wrap_reg   <= wrap_next;
        first_reg  <= first_next;
    end

    assign is_exp     = (func_reg == FUNC_TICK) && (cnt_reg != '0);
    assign n_out      = is_exp ? cnt_reg : NW'(1);
    assign exp_wide   = {{(32-NW){1'b0}}, exp_q};
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign expired    = is_exp;
    assign expired_id = is_exp ? exp_wide[ID_W-1:0] : '0;
    assign alarm_time = alarm_reg;
    assign alarm_on   = alen_reg;
    assign status     = is_exp ? ST_OK : status_reg;
    assign last       = (k_reg == n_out - 1'b1);

endmodule
`default_nettype wire

// File: rtl/core/dltq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "delta_list_timer_queue_assert.svh"
module dltq_checker
    import dltq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [ID_W-1:0]   expired_id,
    input wire logic              expired,
    input wire logic [1:0]        status,
    input wire logic              last
);

    `DLTQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `DLTQ_ASSERT_NEVER(a_one_item, in_ready && out_valid, "input taken during output")
    `DLTQ_ASSERT_IMPL(a_single, out_valid && !expired, last && expired_id == '0, "bad single")
    `DLTQ_ASSERT_IMPL(a_exp_ok, out_valid && expired, status == ST_OK, "status on expiry")

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
`default_nettype wire
